>>> design/sst_pkg.sv
// Shared types and constants for the sorted set table.
`default_nettype none

package sst_pkg;

   // Default sizing of the store.
   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_WIDTH_DEF = 32;

   // Fixed widths of the channel fields.
   localparam int KEY_W   = 32;
   localparam int RANK_W  = 6;
   localparam int COUNT_W = 7;

   // Request kinds.
   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_ERASE    = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_GET      = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_PRESENT = 3'd1,
      ST_ABSENT  = 3'd2,
      ST_RANGE   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   // Sequencer states of the core.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_SHIFT,
      S_PUT,
      S_GET_RD,
      S_REPLY
   } state_type;

   typedef struct packed {
      op_type             req_type;
      logic [KEY_W-1:0]   key;
      logic [RANK_W-1:0]  rank;
   } req_type;

   typedef struct packed {
      logic               ok;
      status_type         status;
      logic [KEY_W-1:0]   key_out;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/sst_core.sv
// Key memory and the search and shift sequencer of the sorted set table.
`default_nettype none

module sst_core #(
   parameter int CAPACITY  = sst_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = sst_pkg::KEY_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire sst_pkg::req_type req,
   input  wire logic             out_free,
   output logic                  idle,
   output logic                  done,
   output sst_pkg::rsp_type      res
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   // Key store, one write port and one registered read port.
   logic [KEY_WIDTH-1:0] mem [CAPACITY];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer registers.
   sst_pkg::state_type   state_ff, state_in;
   sst_pkg::op_type      op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]     src_ff, src_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   sst_pkg::rsp_type     res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sst_pkg::S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      scan_ff      <= scan_in;
      pend_addr_ff <= pend_addr_in;
      src_ff       <= src_in;
      left_ff      <= left_in;
      res_ff       <= res_in;
   end

   // Next state, memory control and result assembly.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      src_in        = src_ff;
      left_in       = left_ff;
      count_in      = count_ff;
      res_in        = res_ff;
      rd_addr       = scan_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = rd_data_ff;
      idle          = 1'b0;
      done          = 1'b0;

      unique case (state_ff)
         sst_pkg::S_IDLE: begin
            idle    = 1'b1;
            rd_addr = AW'(req.rank);
            if (start) begin
               op_in         = req.req_type;
               key_in        = KEY_WIDTH'(req.key);
               scan_in       = '0;
               pend_valid_in = 1'b0;
               res_in.key_out = '0;
               res_in.count   = sst_pkg::COUNT_W'(count_ff);
               if (req.req_type == sst_pkg::OP_GET) begin
                  if (32'(req.rank) < 32'(count_ff)) begin
                     state_in = sst_pkg::S_GET_RD;
                  end else begin
                     res_in.ok     = 1'b0;
                     res_in.status = sst_pkg::ST_RANGE;
                     state_in      = sst_pkg::S_REPLY;
                  end
               end else begin
                  state_in = sst_pkg::S_SEARCH;
               end
            end
         end

         // Walk upward, one read issued per cycle, until a key not below the
         // search key shows up or the count is reached.
         sst_pkg::S_SEARCH: begin
            if (pend_valid_ff && (rd_data_ff >= key_ff)) begin
               pos_in        = CNT_W'(pend_addr_ff);
               found_in      = (rd_data_ff == key_ff);
               pend_valid_in = 1'b0;
               state_in      = sst_pkg::S_DECIDE;
            end else if (scan_ff >= count_ff) begin
               pos_in        = count_ff;
               found_in      = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = sst_pkg::S_DECIDE;
            end else begin
               pend_valid_in = 1'b1;
               pend_addr_in  = scan_ff[AW-1:0];
               scan_in       = scan_ff + ONE_CNT;
            end
         end

         sst_pkg::S_DECIDE: begin
            res_in.ok     = 1'b0;
            res_in.status = sst_pkg::ST_DONE;
            state_in      = sst_pkg::S_REPLY;
            unique case (op_ff)
               sst_pkg::OP_INSERT: begin
                  if (found_ff) begin
                     res_in.status = sst_pkg::ST_PRESENT;
                  end else if (count_ff >= CAP_CNT) begin
                     res_in.status = sst_pkg::ST_FULL;
                  end else begin
                     left_in  = count_ff - pos_ff;
                     src_in   = count_ff - ONE_CNT;
                     state_in = sst_pkg::S_SHIFT;
                  end
               end
               sst_pkg::OP_ERASE: begin
                  if (found_ff) begin
                     left_in  = count_ff - ONE_CNT - pos_ff;
                     src_in   = pos_ff + ONE_CNT;
                     state_in = sst_pkg::S_SHIFT;
                  end else begin
                     res_in.status = sst_pkg::ST_ABSENT;
                  end
               end
               sst_pkg::OP_CONTAINS: begin
                  res_in.ok     = found_ff;
                  res_in.status = found_ff ? sst_pkg::ST_DONE : sst_pkg::ST_ABSENT;
               end
               default: begin
                  res_in.status = sst_pkg::ST_RANGE;
               end
            endcase
         end

         // Move one entry per cycle: the read issued last cycle is written
         // one place up (insert) or down (erase) while the next read goes out.
         sst_pkg::S_SHIFT: begin
            wr_en   = pend_valid_ff;
            rd_addr = src_ff[AW-1:0];
            if (left_ff != '0) begin
               pend_valid_in = 1'b1;
               left_in       = left_ff - ONE_CNT;
               if (op_ff == sst_pkg::OP_INSERT) begin
                  pend_addr_in = AW'(src_ff + ONE_CNT);
                  src_in       = src_ff - ONE_CNT;
               end else begin
                  pend_addr_in = AW'(src_ff - ONE_CNT);
                  src_in       = src_ff + ONE_CNT;
               end
            end else begin
               pend_valid_in = 1'b0;
               if (op_ff == sst_pkg::OP_INSERT) begin
                  state_in = sst_pkg::S_PUT;
               end else begin
                  count_in      = count_ff - ONE_CNT;
                  res_in.ok     = 1'b1;
                  res_in.status = sst_pkg::ST_DONE;
                  res_in.count  = sst_pkg::COUNT_W'(count_ff - ONE_CNT);
                  state_in      = sst_pkg::S_REPLY;
               end
            end
         end

         // Drop the new key into the opened gap.
         sst_pkg::S_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff[AW-1:0];
            wr_data       = key_ff;
            count_in      = count_ff + ONE_CNT;
            res_in.ok     = 1'b1;
            res_in.status = sst_pkg::ST_DONE;
            res_in.count  = sst_pkg::COUNT_W'(count_ff + ONE_CNT);
            state_in      = sst_pkg::S_REPLY;
         end

         sst_pkg::S_GET_RD: begin
            res_in.ok      = 1'b1;
            res_in.status  = sst_pkg::ST_DONE;
            res_in.key_out = sst_pkg::KEY_W'(rd_data_ff);
            state_in       = sst_pkg::S_REPLY;
         end

         // Hand the result over once the output register can take it.
         sst_pkg::S_REPLY: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = sst_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sst_pkg::S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

`default_nettype wire

>>> design/sorted_set_table.sv
// Sorted set table: an ordered store of distinct keys with insert, erase,
// contains and get-by-rank requests.
//
// Requests arrive on the req_ channel (req_valid, req_stall, req_data) and
// one result per request leaves on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_data). An item moves at a clock edge where valid is high and stall is
// low. Keys live in one memory with a registered read port, walked by a
// sequencer that handles one request at a time; req_stall is high from the
// cycle after acceptance until that request's result is in the output register.
// A get reads the key at its rank, or goes straight to the reply for a rank out
// of range; contains is answered by the linear search; insert and erase run the
// search up to the key's place, then a shift of one entry per cycle above it.
// The sequencer is idle again, and can take the next item, as soon as a result
// enters the output register.
// The result waits in the output register while rsp_stall is high; a finished
// result is held in the core until that register frees up.
// Reset empties the store (count zero) and clears rsp_valid; the key memory
// needs no clearing, as only entries below the count are used.
`default_nettype none

module sorted_set_table #(
   parameter int CAPACITY  = sst_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = sst_pkg::KEY_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sst_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sst_pkg::rsp_type      rsp_data
);

   logic             core_idle;
   logic             core_done;
   logic             req_accept;
   logic             out_free;
   sst_pkg::rsp_type core_res;
   logic             rsp_valid_ff, rsp_valid_in;
   sst_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Input side: take an item only while the sequencer is idle.
   assign req_stall  = !core_idle;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   sst_core #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .req      (req_data),
      .out_free (out_free),
      .idle     (core_idle),
      .done     (core_done),
      .res      (core_res)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result reports success exactly when its status is done.
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ok == (rsp_data.status == sst_pkg::ST_DONE)))
      else $error("ok flag disagrees with status");

   // Only a successful request can return a nonzero key.
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != sst_pkg::ST_DONE)) |-> (rsp_data.key_out == '0))
      else $error("failed request returned a key");

   // The count never goes past the capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.count) <= CAPACITY))
      else $error("count exceeds capacity");

   // After an item is taken the sequencer is busy and holds off the next one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input not stalled after accepting an item");

endmodule

`default_nettype wire
